// ===== rtl/core/tvse_pkg.sv =====
package tvse_pkg;

   localparam int MAX_BYTES = 9;
   localparam int CNT_W     = 4;
   localparam int VINT_MAX  = 5;
   localparam int VCNT_W    = 3;

   typedef enum logic [3:0] {
      ACT_NULL   = 4'd0,
      ACT_UNDEF  = 4'd1,
      ACT_BOOL   = 4'd2,
      ACT_INT    = 4'd3,
      ACT_DOUBLE = 4'd4,
      ACT_ARRAY  = 4'd5,
      ACT_MAP    = 4'd6,
      ACT_LENGTH = 4'd7,
      ACT_STRING = 4'd8,
      ACT_RAW    = 4'd9
   } action_type;

   localparam logic [7:0] TAG_NULL     = 8'h00;
   localparam logic [7:0] TAG_UTF8     = 8'h01;
   localparam logic [7:0] TAG_TRUE     = 8'h02;
   localparam logic [7:0] TAG_FALSE    = 8'h03;
   localparam logic [7:0] TAG_INT      = 8'h04;
   localparam logic [7:0] TAG_DOUBLE   = 8'h05;
   localparam logic [7:0] TAG_ARRAY    = 8'h06;
   localparam logic [7:0] TAG_MAP      = 8'h07;
   localparam logic [7:0] TAG_ONE_BYTE = 8'h08;
   localparam logic [7:0] TAG_UNDEF    = 8'hFF;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
   } item_type;

endpackage

// ===== rtl/core/tvse_req_if.sv =====
interface tvse_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [63:0] value;
   logic        one_byte;

   modport source (output valid, output action, output value, output one_byte, input ready);
   modport sink (input valid, input action, input value, input one_byte, output ready);
endinterface

// ===== rtl/core/tvse_rsp_if.sv =====
interface tvse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/tagged_value_stream_encoder_unit.sv =====
// Tagged value stream encoder.
// The req channel takes one serialization event per request (action, value,
// one_byte). The rsp channel returns the encoded bytes of that event one per
// cycle unless rsp stalls, with last set on the final byte of each request.
// Requests with an unused action code produce no bytes.
// A request is registered in the input register, where it is expanded into
// up to nine bytes, and is then loaded into the byte shifter, which drives
// rsp from its lowest byte. A request has one byte for tags and raw bytes,
// two to six for integers and string headers, one to five for lengths and
// nine for doubles. The byte shifter is the limit; the next request is
// accepted while the current one is still being sent, so the rsp channel
// runs without gaps.
// When rsp is stalled, the shifter holds its byte and one further request
// waits in the input register; req.ready then drops.
// Synchronous reset empties both registers; nothing else is cleared.
module tagged_value_stream_encoder_unit import tvse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tvse_req_if.sink      req,
   tvse_rsp_if.source    rsp
);

   logic     take;
   logic     pend_valid;
   item_type pend;

   tvse_format u_format (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .take       (take),
      .pend_valid (pend_valid),
      .pend       (pend)
   );

   tvse_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .pend_valid (pend_valid),
      .pend       (pend),
      .take       (take),
      .rsp        (rsp)
   );

endmodule

// ===== rtl/core/tvse_format.sv =====
module tvse_format import tvse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tvse_req_if.sink      req,
   input  logic          take,
   output logic          pend_valid,
   output item_type      pend
);

   logic                        pend_valid_ff;
   logic                        pend_valid_in;
   item_type                    pend_ff;
   item_type                    item;
   logic                        accept;
   logic [31:0]                 low32;
   logic [31:0]                 zz;
   logic [31:0]                 vsrc;
   logic [4:1]                  nz;
   logic [VINT_MAX-1:0][7:0]    vbytes;
   logic [VCNT_W-1:0]           vcnt;

   assign low32 = req.value[31:0];
   assign zz    = {low32[30:0], 1'b0} ^ {32{low32[31]}};
   assign vsrc  = (req.action == ACT_INT) ? zz : low32;

   // Each varint group carries a continuation bit when any higher group is nonzero.
   always_comb begin
      nz[1] = |vsrc[31:7];
      nz[2] = |vsrc[31:14];
      nz[3] = |vsrc[31:21];
      nz[4] = |vsrc[31:28];
      vbytes[0] = {nz[1], vsrc[6:0]};
      vbytes[1] = {nz[2], vsrc[13:7]};
      vbytes[2] = {nz[3], vsrc[20:14]};
      vbytes[3] = {nz[4], vsrc[27:21]};
      vbytes[4] = {4'b0000, vsrc[31:28]};
      vcnt = 3'd1 + {2'b00, nz[1]} + {2'b00, nz[2]} + {2'b00, nz[3]} + {2'b00, nz[4]};
   end

   always_comb begin
      item.bytes = '0;
      item.count = '0;
      unique case (req.action)
         ACT_NULL: begin
            item.bytes[0] = TAG_NULL;
            item.count    = 4'd1;
         end
         ACT_UNDEF: begin
            item.bytes[0] = TAG_UNDEF;
            item.count    = 4'd1;
         end
         ACT_BOOL: begin
            item.bytes[0] = req.value[0] ? TAG_TRUE : TAG_FALSE;
            item.count    = 4'd1;
         end
         ACT_INT: begin
            item.bytes[0] = TAG_INT;
            for (int k = 0; k < VINT_MAX; k++) begin
               item.bytes[k+1] = vbytes[k];
            end
            item.count = 4'd1 + {1'b0, vcnt};
         end
         ACT_DOUBLE: begin
            item.bytes[0] = TAG_DOUBLE;
            for (int i = 0; i < 8; i++) begin
               item.bytes[i+1] = req.value[63-8*i -: 8];
            end
            item.count = 4'd9;
         end
         ACT_ARRAY: begin
            item.bytes[0] = TAG_ARRAY;
            item.count    = 4'd1;
         end
         ACT_MAP: begin
            item.bytes[0] = TAG_MAP;
            item.count    = 4'd1;
         end
         ACT_LENGTH: begin
            for (int k = 0; k < VINT_MAX; k++) begin
               item.bytes[k] = vbytes[k];
            end
            item.count = {1'b0, vcnt};
         end
         ACT_STRING: begin
            item.bytes[0] = req.one_byte ? TAG_ONE_BYTE : TAG_UTF8;
            for (int k = 0; k < VINT_MAX; k++) begin
               item.bytes[k+1] = vbytes[k];
            end
            item.count = 4'd1 + {1'b0, vcnt};
         end
         ACT_RAW: begin
            item.bytes[0] = req.value[7:0];
            item.count    = 4'd1;
         end
         default: begin
            item.count = '0;
         end
      endcase
   end

   assign req.ready = !pend_valid_ff || take;
   assign accept    = req.valid && req.ready;

   // Requests that encode to nothing are dropped at acceptance.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = (item.count != '0);
      end else if (take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      if (accept) begin
         pend_ff <= item;
      end
   end

   assign pend_valid = pend_valid_ff;
   assign pend       = pend_ff;

endmodule

// ===== rtl/core/tvse_serializer.sv =====
module tvse_serializer import tvse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pend_valid,
   input  item_type      pend,
   output logic          take,
   tvse_rsp_if.source    rsp
);

   logic [MAX_BYTES-1:0][7:0] bytes_ff;
   logic [MAX_BYTES-1:0][7:0] bytes_in;
   logic [CNT_W-1:0]          rem_ff;
   logic [CNT_W-1:0]          rem_in;
   logic                      pop;

   assign rsp.valid    = (rem_ff != '0);
   assign rsp.out_byte = bytes_ff[0];
   assign rsp.last     = (rem_ff == 4'd1);
   assign pop          = rsp.valid && rsp.ready;
   assign take         = pend_valid && ((rem_ff == '0) || (pop && rem_ff == 4'd1));

   always_comb begin
      bytes_in = bytes_ff;
      rem_in   = rem_ff;
      if (take) begin
         bytes_in = pend.bytes;
         rem_in   = pend.count;
      end else if (pop) begin
         bytes_in = {8'h00, bytes_ff[MAX_BYTES-1:1]};
         rem_in   = rem_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      bytes_ff <= bytes_in;
   end

endmodule

// ===== sim/tvse_byte_stream_checker.sv =====
module tvse_byte_stream_checker import tvse_pkg::*; (
   input  logic clock,
   input  logic reset,
   tvse_req_if  req,
   tvse_rsp_if  rsp,
   output int   error_count,
   output int   bytes_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] VARINT_MORE = 8'h80;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } byte_entry_type;

   byte_entry_type expected_bytes[$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count = error_count + 1;
   endtask

   function automatic void push_code(input logic [7:0] code);
      byte_entry_type entry;
      entry.code = code;
      entry.last = 1'b0;
      expected_bytes.push_back(entry);
   endfunction

   function automatic void push_varint(input logic [31:0] length);
      logic [31:0] rest;
      rest = length;
      do begin
         if ((rest >> 7) != 0) begin
            push_code(VARINT_MORE | {1'b0, rest[6:0]});
         end else begin
            push_code({1'b0, rest[6:0]});
         end
         rest = rest >> 7;
      end while (rest != 0);
   endfunction

   function automatic void encode_event(input logic [3:0] action, input logic [63:0] value,
                                        input logic one_byte);
      int          size_before;
      logic [31:0] low_word;
      logic [31:0] zigzag;
      size_before = expected_bytes.size();
      low_word    = value[31:0];
      zigzag      = {low_word[30:0], 1'b0} ^ {32{low_word[31]}};
      case (action)
         ACT_NULL:   push_code(TAG_NULL);
         ACT_UNDEF:  push_code(TAG_UNDEF);
         ACT_BOOL:   push_code(value[0] ? TAG_TRUE : TAG_FALSE);
         ACT_INT: begin
            push_code(TAG_INT);
            push_varint(zigzag);
         end
         ACT_DOUBLE: begin
            push_code(TAG_DOUBLE);
            for (int i = 7; i >= 0; i--) begin
               push_code(value[i*8 +: 8]);
            end
         end
         ACT_ARRAY:  push_code(TAG_ARRAY);
         ACT_MAP:    push_code(TAG_MAP);
         ACT_LENGTH: push_varint(low_word);
         ACT_STRING: begin
            push_code(one_byte ? TAG_ONE_BYTE : TAG_UTF8);
            push_varint(low_word);
         end
         ACT_RAW:    push_code(value[7:0]);
         default: ;
      endcase
      if (expected_bytes.size() > size_before) begin
         expected_bytes[expected_bytes.size()-1].last = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      byte_entry_type head;
      if (reset) begin
         error_count = 0;
         expected_bytes.delete();
      end else begin
         if (req.valid && req.ready) begin
            encode_event(req.action, req.value, req.one_byte);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %h with no request outstanding", rsp.out_byte));
            end else begin
               head = expected_bytes.pop_front();
               if (rsp.out_byte !== head.code) begin
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp.out_byte, head.code));
               end
               if (rsp.last !== head.last) begin
                  report_mismatch($sformatf("last %b, expected %b on byte %h",
                                            rsp.last, head.last, head.code));
               end
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

// ===== sim/tagged_value_stream_encoder_unit_tb.sv =====
module tagged_value_stream_encoder_unit_tb;
   import tvse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQUESTS_PER_PHASE = 58;
   localparam int DRAIN_CYCLES       = 20;

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   error_count;
   int   bytes_pending;

   tvse_req_if req_bus ();
   tvse_rsp_if rsp_bus ();

   tagged_value_stream_encoder_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   tvse_byte_stream_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .error_count   (error_count),
      .bytes_pending (bytes_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_request(input logic [3:0] action, input logic [63:0] value,
                               input logic one_byte);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= action;
      req_bus.value    <= value;
      req_bus.one_byte <= one_byte;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [3:0]  action;
      logic [63:0] payload;
      int          sent;
      reset              = 1'b1;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_NULL;
      req_bus.value      = '0;
      req_bus.one_byte   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(ACT_NULL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_request(ACT_UNDEF, 64'h0, 1'b0);
      send_request(ACT_BOOL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(ACT_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      send_request(ACT_INT, 64'h0, 1'b0);
      send_request(ACT_INT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(ACT_INT, 64'h0000_003F, 1'b0);
      send_request(ACT_INT, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0);
      send_request(ACT_INT, 64'h0000_0040, 1'b1);
      send_request(ACT_INT, 64'h0000_0000_7FFF_FFFF, 1'b0);
      send_request(ACT_INT, 64'hFFFF_FFFF_8000_0000, 1'b0);
      send_request(ACT_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(ACT_DOUBLE, 64'h0123_4567_89AB_CDEF, 1'b1);
      send_request(ACT_ARRAY, 64'h0, 1'b0);
      send_request(ACT_MAP, 64'h0, 1'b1);
      send_request(ACT_LENGTH, 64'h0, 1'b0);
      send_request(ACT_LENGTH, 64'h0000_0080, 1'b0);
      send_request(ACT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(ACT_LENGTH, 64'h0000_0001_0000_0005, 1'b1);
      send_request(ACT_STRING, 64'h0, 1'b1);
      send_request(ACT_STRING, 64'hABCD_0000_0000_012C, 1'b0);
      send_request(ACT_RAW, 64'h0, 1'b0);
      send_request(ACT_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_request(4'(ACT_RAW + 1), 64'h1234, 1'b0);
      send_request(4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
         endcase
         sent = 0;
         while (sent < REQUESTS_PER_PHASE) begin
            if ($urandom_range(19) == 0) begin
               action = 4'($urandom_range(15, ACT_RAW + 1));
            end else begin
               action = 4'($urandom_range(ACT_RAW));
               sent++;
            end
            payload = {$urandom, $urandom};
            case ($urandom_range(3))
               0: payload = payload >> $urandom_range(63);
               1: payload = ~(payload >> $urandom_range(63));
               default: ;
            endcase
            send_request(action, payload, 1'($urandom_range(1)));
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (bytes_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
